>>> design/tqps_pkg.sv
// Shared types, codes and the slot pattern table for the three-queue scheduler.
`timescale 1ns / 1ps

package tqps_pkg;

  // Field widths of the stream words
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ID_FIELD_W = 16;
  localparam int unsigned PRIO_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TDATA_W   = 24;
  localparam int unsigned TUSER_W   = 2;

  // Pattern
  localparam int unsigned PATTERN_LEN = 19;
  localparam int unsigned PAT_W       = 5;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // latch the incoming word, clear the result
    logic push;       // append id to its queue or flag full
    logic set_empty;  // schedule found every queue empty
    logic scan_step;  // take the queue of the current slot, advance the pointer
    logic pop_rd;     // read the head of the selected queue
    logic pop_fin;    // deliver the head, retire it
    logic rm_rd;      // read entry idx of the selected queue
    logic rm_hit;     // entry matched
    logic rm_adv;     // no match, step idx
    logic rm_nextq;   // move to the next queue
    logic shift_rd;   // read entry idx+1
    logic shift_wr;   // write it back at idx, step idx
    logic rm_del;     // drop the tail slot, move to the next queue
    logic rm_fin;     // settle the remove status
    logic out_load;   // move the result into the output register
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             all_empty;
    logic             cur_nonempty;
    logic             idx_in;
    logic             match;
    logic             shift_more;
    logic             q_last;
    logic             out_free;
  } dp_stat_t;

  // Weighted slot pattern: queue served at each slot
  function automatic logic [PRIO_W-1:0] slot_prio(input logic [PAT_W-1:0] slot);
    logic [PRIO_W-1:0] q;
    case (slot)
      5'd0:    q = 2'd0;
      5'd1:    q = 2'd1;
      5'd2:    q = 2'd2;
      5'd3:    q = 2'd0;
      5'd4:    q = 2'd0;
      5'd5:    q = 2'd1;
      5'd6:    q = 2'd0;
      5'd7:    q = 2'd1;
      5'd8:    q = 2'd2;
      5'd9:    q = 2'd0;
      5'd10:   q = 2'd0;
      5'd11:   q = 2'd1;
      5'd12:   q = 2'd2;
      5'd13:   q = 2'd0;
      5'd14:   q = 2'd1;
      5'd15:   q = 2'd0;
      5'd16:   q = 2'd0;
      5'd17:   q = 2'd1;
      5'd18:   q = 2'd2;
      default: q = 2'd0;
    endcase
    return q;
  endfunction

endpackage

>>> design/tqps_ctrl.sv
// Sequencing state machine of the three-queue scheduler.
`timescale 1ns / 1ps

module tqps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  tqps_pkg::dp_stat_t stat_i,
  output tqps_pkg::dp_cmd_t  ctrl_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_POP_FIN = 4'd3;
  localparam logic [3:0] S_RM_CHK  = 4'd4;
  localparam logic [3:0] S_RM_CMP  = 4'd5;
  localparam logic [3:0] S_SH_CHK  = 4'd6;
  localparam logic [3:0] S_SH_WR   = 4'd7;
  localparam logic [3:0] S_RM_FIN  = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0] state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.cmd)
          tqps_pkg::CMD_PUSH: begin
            ctrl_o.push = 1'b1;
            state_d     = S_RESP;
          end
          tqps_pkg::CMD_SCHED: begin
            if (stat_i.all_empty) begin
              ctrl_o.set_empty = 1'b1;
              state_d          = S_RESP;
            end else begin
              ctrl_o.scan_step = 1'b1;
              state_d          = S_SCAN;
            end
          end
          tqps_pkg::CMD_REMOVE: state_d = S_RM_CHK;
          default:              state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        // one slot per cycle until a non-empty queue comes up
        if (stat_i.cur_nonempty) begin
          ctrl_o.pop_rd = 1'b1;
          state_d       = S_POP_FIN;
        end else begin
          ctrl_o.scan_step = 1'b1;
        end
      end
      S_POP_FIN: begin
        ctrl_o.pop_fin = 1'b1;
        state_d        = S_RESP;
      end
      S_RM_CHK: begin
        if (stat_i.idx_in) begin
          ctrl_o.rm_rd = 1'b1;
          state_d      = S_RM_CMP;
        end else if (stat_i.q_last) begin
          state_d = S_RM_FIN;
        end else begin
          ctrl_o.rm_nextq = 1'b1;
        end
      end
      S_RM_CMP: begin
        if (stat_i.match) begin
          ctrl_o.rm_hit = 1'b1;
          state_d       = S_SH_CHK;
        end else begin
          ctrl_o.rm_adv = 1'b1;
          state_d       = S_RM_CHK;
        end
      end
      S_SH_CHK: begin
        if (stat_i.shift_more) begin
          ctrl_o.shift_rd = 1'b1;
          state_d         = S_SH_WR;
        end else begin
          ctrl_o.rm_del = 1'b1;
          state_d       = stat_i.q_last ? S_RM_FIN : S_RM_CHK;
        end
      end
      S_SH_WR: begin
        ctrl_o.shift_wr = 1'b1;
        state_d         = S_SH_CHK;
      end
      S_RM_FIN: begin
        ctrl_o.rm_fin = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/tqps_datapath.sv
// Queue storage, counts, pattern pointer and result registers of the scheduler.
`timescale 1ns / 1ps

module tqps_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tqps_pkg::TDATA_W-1:0]   s_tdata_i,
  input  logic [tqps_pkg::TUSER_W-1:0]   s_tuser_i,
  input  tqps_pkg::dp_cmd_t              ctrl_i,
  output tqps_pkg::dp_stat_t             stat_o,
  input  logic                           m_tready_i,
  output logic                           m_tvalid_o,
  output logic [tqps_pkg::TDATA_W-1:0]   m_tdata_o,
  output logic [tqps_pkg::TUSER_W-1:0]   m_tuser_o
);

  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned MEM_DEPTH = 3 * QUEUE_DEPTH;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned PAD_W     = tqps_pkg::TDATA_W - tqps_pkg::ID_FIELD_W
                                      - tqps_pkg::PRIO_W;

  // Latched request
  logic [tqps_pkg::CMD_W-1:0]    cmd_q;
  logic [ID_BITS-1:0]            id_q;
  logic [tqps_pkg::PRIO_W-1:0]   prio_q;

  // Queue bookkeeping (circular buffers in one memory, one region per queue)
  logic [CNT_W-1:0]              cnt_q  [3];
  logic [IDX_W-1:0]              head_q [3];
  logic [tqps_pkg::PAT_W-1:0]    ptr_q;
  logic [1:0]                    q_sel_q;
  logic [CNT_W-1:0]              idx_q;    // runs up to the fill count
  logic                          found_q;
  logic [ID_BITS-1:0]            mem_q  [MEM_DEPTH];
  logic [ID_BITS-1:0]            rd_data_q;

  // Result and output register
  logic [tqps_pkg::STATUS_W-1:0]   res_status_q;
  logic [tqps_pkg::ID_FIELD_W-1:0] res_id_q;
  logic [tqps_pkg::PRIO_W-1:0]     res_prio_q;
  logic                            out_valid_q;
  logic [tqps_pkg::STATUS_W-1:0]   out_status_q;
  logic [tqps_pkg::ID_FIELD_W-1:0] out_id_q;
  logic [tqps_pkg::PRIO_W-1:0]     out_prio_q;

  logic [1:0]       cur_q;
  logic [CNT_W-1:0] cur_cnt;
  logic [IDX_W-1:0] cur_head;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W:0]   head_sum;
  logic             cur_valid;
  logic             full;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] wr_off;
  logic [IDX_W-1:0] rd_off;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [ID_BITS-1:0] wr_data;

  // Physical address of logical entry off in queue q
  function automatic logic [AW-1:0] phys(input logic [1:0] q,
                                         input logic [IDX_W-1:0] hd,
                                         input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    logic [AW-1:0]  base;
    sum = {1'b0, hd} + {1'b0, off};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    case (q)
      2'd1:    base = AW'(QUEUE_DEPTH);
      2'd2:    base = AW'(2 * QUEUE_DEPTH);
      default: base = '0;
    endcase
    return base + AW'(sum);
  endfunction

  // push works on its own priority, everything else on the selected queue
  assign cur_q = (cmd_q == tqps_pkg::CMD_PUSH) ? prio_q : q_sel_q;

  always_comb begin
    case (cur_q)
      2'd0: begin
        cur_cnt   = cnt_q[0];
        cur_head  = head_q[0];
        cur_valid = 1'b1;
      end
      2'd1: begin
        cur_cnt   = cnt_q[1];
        cur_head  = head_q[1];
        cur_valid = 1'b1;
      end
      2'd2: begin
        cur_cnt   = cnt_q[2];
        cur_head  = head_q[2];
        cur_valid = 1'b1;
      end
      default: begin
        cur_cnt   = '0;
        cur_head  = '0;
        cur_valid = 1'b0;
      end
    endcase
  end

  assign full     = !cur_valid || (cur_cnt == CNT_W'(QUEUE_DEPTH));
  assign head_sum = {1'b0, cur_head} + (IDX_W+1)'(1);
  assign head_inc = (head_sum == (IDX_W+1)'(QUEUE_DEPTH)) ? '0 : head_sum[IDX_W-1:0];

  assign wr_off  = ctrl_i.push ? cur_cnt[IDX_W-1:0] : idx_q[IDX_W-1:0];
  assign rd_off  = ctrl_i.pop_rd   ? '0 :
                   ctrl_i.shift_rd ? idx_q[IDX_W-1:0] + IDX_W'(1) : idx_q[IDX_W-1:0];
  assign wr_addr = phys(cur_q, cur_head, wr_off);
  assign rd_addr = phys(cur_q, cur_head, rd_off);
  assign mem_we  = (ctrl_i.push && !full) || ctrl_i.shift_wr;
  assign mem_re  = ctrl_i.pop_rd || ctrl_i.rm_rd || ctrl_i.shift_rd;
  assign wr_data = ctrl_i.push ? id_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= s_tuser_i[tqps_pkg::CMD_W-1:0];
      id_q   <= ID_BITS'(s_tdata_i[tqps_pkg::ID_FIELD_W-1:0]);
      prio_q <= s_tdata_i[tqps_pkg::ID_FIELD_W +: tqps_pkg::PRIO_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
      ptr_q   <= '0;
      q_sel_q <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (cur_q == 2'(i)) begin
          if (ctrl_i.push && !full) begin
            cnt_q[i] <= cnt_q[i] + CNT_W'(1);
          end
          if (ctrl_i.pop_fin) begin
            cnt_q[i]  <= cnt_q[i] - CNT_W'(1);
            head_q[i] <= head_inc;
          end
          if (ctrl_i.rm_del) begin
            cnt_q[i] <= cnt_q[i] - CNT_W'(1);
          end
        end
      end
      if (ctrl_i.scan_step) begin
        q_sel_q <= tqps_pkg::slot_prio(ptr_q);
        ptr_q   <= (ptr_q == tqps_pkg::PAT_W'(tqps_pkg::PATTERN_LEN - 1)) ?
                   '0 : ptr_q + tqps_pkg::PAT_W'(1);
      end
      if (ctrl_i.load) begin
        q_sel_q <= '0;
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      if (ctrl_i.rm_nextq || ctrl_i.rm_del) begin
        q_sel_q <= q_sel_q + 2'd1;
        idx_q   <= '0;
      end
      if (ctrl_i.rm_adv || ctrl_i.shift_wr) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (ctrl_i.rm_hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      res_status_q <= tqps_pkg::ST_OK;
      res_id_q     <= '0;
      res_prio_q   <= '0;
    end
    if (ctrl_i.push && full) begin
      res_status_q <= tqps_pkg::ST_FULL;
    end
    if (ctrl_i.set_empty) begin
      res_status_q <= tqps_pkg::ST_EMPTY;
    end
    if (ctrl_i.pop_fin) begin
      res_id_q   <= tqps_pkg::ID_FIELD_W'(rd_data_q);
      res_prio_q <= q_sel_q;
    end
    if (ctrl_i.rm_fin && !found_q) begin
      res_status_q <= tqps_pkg::ST_NOT_FOUND;
    end
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_prio_q   <= res_prio_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {PAD_W'(0), out_prio_q, out_id_q};
  assign m_tuser_o  = out_status_q;

  assign stat_o.cmd          = cmd_q;
  assign stat_o.all_empty    = (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0);
  assign stat_o.cur_nonempty = (cur_cnt != '0);
  assign stat_o.idx_in       = (idx_q < cur_cnt);
  assign stat_o.match        = (rd_data_q == id_q);
  assign stat_o.shift_more   = ((idx_q + CNT_W'(1)) < cur_cnt);
  assign stat_o.q_last       = (q_sel_q == 2'd2);
  assign stat_o.out_free     = !out_valid_q || m_tready_i;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q < tqps_pkg::PAT_W'(tqps_pkg::PATTERN_LEN))
    else $error("pattern pointer out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_W'(QUEUE_DEPTH)) && (cnt_q[1] <= CNT_W'(QUEUE_DEPTH)) &&
    (cnt_q[2] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop_fin |-> (cur_cnt != '0) && cur_valid)
    else $error("pop from an empty queue");

  a_shift_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.shift_rd |=> ctrl_i.shift_wr && (idx_q + CNT_W'(1) < cur_cnt))
    else $error("compaction write lost or past the fill count");
`endif

endmodule

>>> design/three_queue_pattern_scheduler.sv
// Top level of the three-queue weighted pattern scheduler.
`timescale 1ns / 1ps

// Three FIFO run queues (priority 0, 1, 2) of process ids, served by a fixed
// 19-slot weighted pattern (0,1,2,0,0,1,0,1,2,0,0,1,2,0,1,0,0,1,2). Each input
// word carries a command in tuser: push appends proc_id to queue prio (status
// full if that queue holds QUEUE_DEPTH ids or prio is 3), schedule pops the
// head of the first non-empty queue met by the wrapping pattern pointer and
// leaves the pointer one slot past it (status empty if all queues are empty),
// remove deletes the first matching id from each queue keeping order (status
// not found if no queue held it). One result word per input word, in order.
// Work is done one word at a time by a sequencer over a single-port queue
// memory with a registered read, one access per cycle: a schedule walks the
// pattern slot by slot and skips at most 5 empty slots, a remove examines the
// ids of each queue in turn and moves up the entries behind each hit. A new
// word is taken while the previous result still waits at the output, and the
// block needs no clearing pass after reset.
module three_queue_pattern_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,  // ids per queue, 2..256
  parameter int unsigned ID_BITS     = 16   // stored id width, 4..32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request words
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [tqps_pkg::TDATA_W-1:0] s_axis_tdata_i,  // proc_id[15:0], prio[17:16], zero
  input  logic [tqps_pkg::TUSER_W-1:0] s_axis_tuser_i,  // cmd[1:0]
  // result words
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [tqps_pkg::TDATA_W-1:0] m_axis_tdata_o,  // granted_id[15:0], granted_prio[17:16], zero
  output logic [tqps_pkg::TUSER_W-1:0] m_axis_tuser_o   // status[1:0]
);

  tqps_pkg::dp_cmd_t  ctrl;
  tqps_pkg::dp_stat_t stat;

  // Sequencer: decodes the command and steps the queue operations
  tqps_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  // Queue memory, counts, heads, pattern pointer and output register
  tqps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> sim/tb_three_queue_pattern_scheduler.sv
// Self-checking testbench for the three-queue weighted pattern scheduler.
`timescale 1ns / 1ps

module tb_three_queue_pattern_scheduler;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 250;   // longer than the slowest remove

  // Command 3 is a no-op, priority 3 names no queue
  localparam logic [tqps_pkg::CMD_W-1:0]  CMD_IDLE     = 2'd3;
  localparam logic [tqps_pkg::PRIO_W-1:0] PRIO_INVALID = 2'd3;

  // Queue served at each pattern slot, slot 0 in the lowest two bits
  localparam logic [2*tqps_pkg::PATTERN_LEN-1:0] SLOT_MAP = {
    2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic [tqps_pkg::STATUS_W-1:0]   status;
    logic [tqps_pkg::ID_FIELD_W-1:0] gid;
    logic [tqps_pkg::PRIO_W-1:0]     gprio;
  } grant_word_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [tqps_pkg::TDATA_W-1:0]  s_axis_tdata_i  = '0;  // proc_id[15:0], prio[17:16], zero
  logic [tqps_pkg::TUSER_W-1:0]  s_axis_tuser_i  = '0;  // cmd[1:0]
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [tqps_pkg::TDATA_W-1:0]  m_axis_tdata_o;        // granted_id[15:0], granted_prio[17:16], zero
  logic [tqps_pkg::TUSER_W-1:0]  m_axis_tuser_o;        // status[1:0]

  // Shadow scheduler state
  logic [tqps_pkg::ID_FIELD_W-1:0] run_ids [3][QUEUE_DEPTH];
  int unsigned                     run_fill [3] = '{0, 0, 0};
  int unsigned                     slot_ptr = 0;

  grant_word_t pending_grants[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on     = 1'b1;  // random idle on both sides when set

  three_queue_pattern_scheduler #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (16)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // Runaway guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_three_queue_pattern_scheduler: errors");
      $finish;
    end
  end

  // Applies one command to the shadow queues and returns the word it must produce
  function automatic grant_word_t schedule_grant(
      input logic [tqps_pkg::CMD_W-1:0]      cmd,
      input logic [tqps_pkg::ID_FIELD_W-1:0] id,
      input logic [tqps_pkg::PRIO_W-1:0]     prio);
    grant_word_t res;
    bit          found;
    bit          hit;
    logic [1:0]  qsel;
    res = '{status: tqps_pkg::ST_OK, gid: '0, gprio: '0};
    found = 1'b0;
    case (cmd)
      tqps_pkg::CMD_PUSH: begin
        if (prio == PRIO_INVALID || run_fill[prio] == QUEUE_DEPTH) begin
          res.status = tqps_pkg::ST_FULL;
        end else begin
          run_ids[prio][run_fill[prio]] = id;
          run_fill[prio]++;
        end
      end
      tqps_pkg::CMD_SCHED: begin
        if (run_fill[0] == 0 && run_fill[1] == 0 && run_fill[2] == 0) begin
          res.status = tqps_pkg::ST_EMPTY;  // pointer stays put
        end else begin
          // walk the pattern, skipping slots whose queue is empty
          for (int t = 0; t < tqps_pkg::PATTERN_LEN && !found; t++) begin
            qsel     = SLOT_MAP[2*slot_ptr +: 2];
            slot_ptr = (slot_ptr + 1) % tqps_pkg::PATTERN_LEN;
            if (run_fill[qsel] != 0) begin
              found     = 1'b1;
              res.gid   = run_ids[qsel][0];
              res.gprio = qsel;
              for (int k = 0; k + 1 < run_fill[qsel]; k++)
                run_ids[qsel][k] = run_ids[qsel][k+1];
              run_fill[qsel]--;
            end
          end
        end
      end
      tqps_pkg::CMD_REMOVE: begin
        // first match in each queue goes, the rest close up in order
        for (int q = 0; q < 3; q++) begin
          hit = 1'b0;
          for (int i = 0; i < run_fill[q] && !hit; i++) begin
            if (run_ids[q][i] == id) begin
              hit = 1'b1;
              for (int k = i; k + 1 < run_fill[q]; k++)
                run_ids[q][k] = run_ids[q][k+1];
            end
          end
          if (hit) begin
            run_fill[q]--;
            found = 1'b1;
          end
        end
        if (!found) res.status = tqps_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Sends one request word; called at a rising edge, returns at the accepting edge
  task automatic send_word(input logic [tqps_pkg::CMD_W-1:0]      cmd,
                           input logic [tqps_pkg::ID_FIELD_W-1:0] id,
                           input logic [tqps_pkg::PRIO_W-1:0]     prio);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, prio, id};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_grants.push_back(schedule_grant(cmd, id, prio));
  endtask

  // Result side back-pressure: a fresh stall draw for every word
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = gaps_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Result checker: every accepted word against the oldest expectation
  always @(posedge clk_i) begin
    grant_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = pending_grants.pop_front();
        if (m_axis_tuser_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser_o, want.status));
        if (m_axis_tdata_o[15:0] !== want.gid)
          report_mismatch($sformatf("granted_id %h, want %h",
                                    m_axis_tdata_o[15:0], want.gid));
        if (m_axis_tdata_o[17:16] !== want.gprio)
          report_mismatch($sformatf("granted_prio %0d, want %0d",
                                    m_axis_tdata_o[17:16], want.gprio));
      end
    end
  end

  // Empty queues: schedule, remove, the no-op command and the bad priority
  task automatic test_idle_queues();
    send_word(tqps_pkg::CMD_SCHED, 16'h0000, 2'd0);
    send_word(tqps_pkg::CMD_REMOVE, 16'h1234, 2'd0);
    send_word(CMD_IDLE, 16'hFFFF, PRIO_INVALID);
    send_word(tqps_pkg::CMD_PUSH, 16'hFFFF, PRIO_INVALID);
  endtask

  // Fill the lowest-weight queue to the brim, then one more
  task automatic test_queue_full();
    logic [15:0] id;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0)      id = 16'h0000;
      else if (i == 1) id = 16'hFFFF;
      else             id = (i % 2 != 0) ? 16'(16'hA5A0 + i) : 16'(16'h5A50 + i);
      send_word(tqps_pkg::CMD_PUSH, id, 2'd2);
    end
    send_word(tqps_pkg::CMD_PUSH, 16'h8001, 2'd2);
  endtask

  // Same id in two queues goes from both; grants then skip the empty slots
  task automatic test_remove_and_grant();
    send_word(tqps_pkg::CMD_PUSH, 16'hFFFF, 2'd0);
    send_word(tqps_pkg::CMD_REMOVE, 16'hFFFF, 2'd1);
    send_word(tqps_pkg::CMD_SCHED, 16'h0000, 2'd0);
    send_word(tqps_pkg::CMD_SCHED, 16'hFFFF, 2'd3);
  endtask

  // Every 100 words a new push weight is drawn and idle is turned on or off at random
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned    pick;
    int unsigned    push_weight;
    int unsigned    q;
    logic [tqps_pkg::CMD_W-1:0]  cmd;
    logic [tqps_pkg::PRIO_W-1:0] prio;
    logic [15:0]                 id;
    push_weight = 50;
    for (int i = 0; i < n_words; i++) begin
      if (i % 100 == 0) begin
        gaps_on     = ($urandom_range(0, 3) != 0);
        push_weight = $urandom_range(25, 70);
      end
      pick = $urandom_range(0, 99);
      prio = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 39) == 0) prio = PRIO_INVALID;
      id = 16'($urandom);
      if ($urandom_range(0, 3) == 0) id = 16'($urandom_range(0, 7));  // repeats across queues
      if (pick < push_weight)  cmd = tqps_pkg::CMD_PUSH;
      else if (pick < 88)      cmd = tqps_pkg::CMD_SCHED;
      else if (pick < 98)      cmd = tqps_pkg::CMD_REMOVE;
      else                     cmd = CMD_IDLE;
      // most removes target an id that is queued right now
      if (cmd == tqps_pkg::CMD_REMOVE && $urandom_range(0, 2) != 0) begin
        q = $urandom_range(0, 2);
        for (int t = 0; t < 3; t++) begin
          if (run_fill[(q + t) % 3] != 0) begin
            q  = (q + t) % 3;
            id = run_ids[q][$urandom_range(0, run_fill[q] - 1)];
            break;
          end
        end
      end
      send_word(cmd, id, prio);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_queues();
    test_queue_full();
    test_remove_and_grant();
    test_random_traffic(650);
    s_axis_tvalid_i <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_three_queue_pattern_scheduler: clean");
    end else begin
      $display("tb_three_queue_pattern_scheduler: errors");
    end
    $finish;
  end

endmodule
